FILE: design/assert_macros.svh
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcr: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define GCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcr: next-cycle check failed");

`endif

FILE: design/gcr_pkg.sv
package gcr_pkg;

    localparam int DEF_NUM_PINS = 54;
    localparam int CMD_W        = 2;
    localparam int IDX_W        = 5;
    localparam int DATA_W       = 32;

    // Function select layout: 3 bits per pin, 10 pins per word, 6 words.
    localparam int FSEL_W       = 3;
    localparam int FSEL_FIELDS  = 10;
    localparam int FSEL_REGS    = 6;
    localparam int FSEL_WORD_W  = FSEL_W * FSEL_FIELDS;
    localparam logic [FSEL_W-1:0] FSEL_OUTPUT = 3'b001;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    // Register map (last index of each range)
    localparam logic [IDX_W-1:0] REG_FSEL_LAST = 5'd5;
    localparam logic [IDX_W-1:0] REG_SET_LAST  = 5'd7;
    localparam logic [IDX_W-1:0] REG_CLR_LAST  = 5'd9;
    localparam logic [IDX_W-1:0] REG_LEV_LAST  = 5'd11;
    localparam logic [IDX_W-1:0] REG_EDS_LAST  = 5'd13;
    localparam logic [IDX_W-1:0] REG_REN_LAST  = 5'd15;
    localparam logic [IDX_W-1:0] REG_FEN_LAST  = 5'd17;
    localparam logic [IDX_W-1:0] REG_PUD       = 5'd18;
    localparam logic [IDX_W-1:0] REG_PUDCLK1   = 5'd20;

    // Pull codes
    localparam logic [1:0] PULL_DOWN = 2'd1;
    localparam logic [1:0] PULL_UP   = 2'd2;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_UNMAPPED = 1'b1;

endpackage

FILE: design/gpio_controller_registers.sv
// GPIO register block.
// Input stream (s_axis_*): one beat is a register write, a register read or a
// sample of the external pin levels, chosen by s_axis_tuser. Register writes
// and reads address the bank of function select, set, clear, level, event,
// rising/falling enable and pull registers through reg_index.
// Output stream (m_axis_*): one beat per input beat, in order, carrying the
// read data, the pin-facing outputs after the access and the two bank
// interrupt lines; m_axis_tuser flags an unmapped register index.
// The result appears in the cycle after the input beat is accepted.
// Throughput: one beat per cycle unless stalled; one result register sets both.
// While the receiver stalls, the result register holds its beat and
// s_axis_tready drops; when it is drained the same cycle a new beat may enter.
// Reset clears all pin state (all pins inputs, latch, enables, events and
// pulls zero) and empties the result register.
module gpio_controller_registers
#(
    parameter int NUM_PINS = gcr_pkg::DEF_NUM_PINS
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // reg_index, write_data, pin_levels
    input  logic [((gcr_pkg::IDX_W + gcr_pkg::DATA_W + NUM_PINS + 7) / 8) * 8 - 1:0]
                                                       s_axis_tdata,
    // command
    input  logic [gcr_pkg::CMD_W-1:0]                  s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // read_data, out_level, out_enable, pull_up_mask, pull_down_mask,
    // irq_bank0, irq_bank1
    output logic [((gcr_pkg::DATA_W + 4 * NUM_PINS + 2 + 7) / 8) * 8 - 1:0]
                                                       m_axis_tdata,
    // status
    output logic                                       m_axis_tuser
);
    import gcr_pkg::*;

    `include "assert_macros.svh"

    localparam int M_TDATA_W = ((DATA_W + 4 * NUM_PINS + 2 + 7) / 8) * 8;
    localparam int LEV_LSB   = IDX_W + DATA_W;

    logic                load;
    logic [IDX_W-1:0]    reg_index;
    logic [DATA_W-1:0]   write_data;
    logic [NUM_PINS-1:0] pin_levels;
    logic [DATA_W-1:0]   read_data;
    logic [NUM_PINS-1:0] out_level;
    logic [NUM_PINS-1:0] out_enable;
    logic [NUM_PINS-1:0] pull_up_mask;
    logic [NUM_PINS-1:0] pull_down_mask;
    logic                irq_bank0;
    logic                irq_bank1;

    assign reg_index  = s_axis_tdata[IDX_W-1:0];
    assign write_data = s_axis_tdata[IDX_W +: DATA_W];
    assign pin_levels = s_axis_tdata[LEV_LSB +: NUM_PINS];

    gcr_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .load    (load)
    );

    gcr_datapath #(.NUM_PINS(NUM_PINS)) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .command        (s_axis_tuser),
        .reg_index      (reg_index),
        .write_data     (write_data),
        .pin_levels     (pin_levels),
        .read_data      (read_data),
        .status         (m_axis_tuser),
        .out_level      (out_level),
        .out_enable     (out_enable),
        .pull_up_mask   (pull_up_mask),
        .pull_down_mask (pull_down_mask),
        .irq_bank0      (irq_bank0),
        .irq_bank1      (irq_bank1)
    );

    assign m_axis_tdata = M_TDATA_W'({irq_bank1, irq_bank0, pull_down_mask, pull_up_mask,
                                      out_enable, out_level, read_data});

    `GCR_ASSERT_NEXT(a_accept_gives_result, clk, rst_n,
        s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    `GCR_ASSERT_IMPLY(a_no_overwrite_on_stall, clk, rst_n,
        m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `GCR_ASSERT_NEXT(a_sample_status_ok, clk, rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_SAMPLE,
        m_axis_tuser == STATUS_OK)

endmodule

FILE: design/gcr_ctrl.sv
module gcr_ctrl
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output logic load
);
    import gcr_pkg::*;

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;

    // Take a new beat whenever the result register is empty or being drained.
    assign s_ready = (state_reg == ST_EMPTY) || m_ready;
    assign m_valid = (state_reg == ST_FULL);
    assign load    = s_valid && s_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (s_valid)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (m_ready && !s_valid)
                begin
                    state_next = ST_EMPTY;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/gcr_datapath.sv
module gcr_datapath
#(
    parameter int NUM_PINS = gcr_pkg::DEF_NUM_PINS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [gcr_pkg::CMD_W-1:0]   command,
    input  logic [gcr_pkg::IDX_W-1:0]   reg_index,
    input  logic [gcr_pkg::DATA_W-1:0]  write_data,
    input  logic [NUM_PINS-1:0]         pin_levels,
    output logic [gcr_pkg::DATA_W-1:0]  read_data,
    output logic                        status,
    output logic [NUM_PINS-1:0]         out_level,
    output logic [NUM_PINS-1:0]         out_enable,
    output logic [NUM_PINS-1:0]         pull_up_mask,
    output logic [NUM_PINS-1:0]         pull_down_mask,
    output logic                        irq_bank0,
    output logic                        irq_bank1
);
    import gcr_pkg::*;

    localparam int WIDE_W = 2 * DATA_W;

    // Pin state
    logic [FSEL_WORD_W-1:0] fsel_reg [FSEL_REGS];
    logic [FSEL_WORD_W-1:0] fsel_next [FSEL_REGS];
    logic [FSEL_WORD_W-1:0] fsel_mask [FSEL_REGS];
    logic [NUM_PINS-1:0]    latch_reg, latch_next;
    logic [NUM_PINS-1:0]    ren_reg, ren_next;
    logic [NUM_PINS-1:0]    fen_reg, fen_next;
    logic [NUM_PINS-1:0]    event_reg, event_next;
    logic [NUM_PINS-1:0]    sample_reg, sample_next;
    logic [NUM_PINS-1:0]    pu_reg, pu_next;
    logic [NUM_PINS-1:0]    pd_reg, pd_next;
    logic [1:0]             pull_ctl_reg, pull_ctl_next;

    // Result register
    logic [DATA_W-1:0]      rd_out_reg;
    logic                   status_out_reg;
    logic [NUM_PINS-1:0]    level_out_reg;
    logic [NUM_PINS-1:0]    oe_out_reg;
    logic [NUM_PINS-1:0]    pu_out_reg;
    logic [NUM_PINS-1:0]    pd_out_reg;
    logic                   irq0_out_reg;
    logic                   irq1_out_reg;

    logic [DATA_W-1:0]      rd_comb;
    logic                   status_comb;
    logic                   wr;
    logic                   bank;
    logic                   pudclk_bank;
    logic [2:0]             fsel_idx;
    logic [NUM_PINS-1:0]    wd_bits;
    logic [NUM_PINS-1:0]    bank_sel;
    logic [NUM_PINS-1:0]    pudclk_hit;
    logic [NUM_PINS-1:0]    oe_comb;
    logic [WIDE_W-1:0]      event_wide;

    function automatic logic [NUM_PINS-1:0] bank_bits(input logic [DATA_W-1:0] word,
                                                      input logic sel);
        logic [WIDE_W-1:0] wide;
        wide = sel ? {word, {DATA_W{1'b0}}} : {{DATA_W{1'b0}}, word};
        return wide[NUM_PINS-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] bank_word(input logic [NUM_PINS-1:0] bits,
                                                    input logic sel);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(bits);
        return sel ? wide[WIDE_W-1:DATA_W] : wide[DATA_W-1:0];
    endfunction

    // Fields of pins past the last pin stay zero.
    always_comb
    begin
        for (int w = 0; w < FSEL_REGS; w++)
        begin
            for (int k = 0; k < FSEL_FIELDS; k++)
            begin
                fsel_mask[w][k*FSEL_W +: FSEL_W] =
                    (w * FSEL_FIELDS + k < NUM_PINS) ? {FSEL_W{1'b1}} : {FSEL_W{1'b0}};
            end
        end
    end

    assign wr          = (command == CMD_WRITE);
    assign bank        = reg_index[0];
    assign pudclk_bank = (reg_index == REG_PUDCLK1);
    assign fsel_idx    = reg_index[2:0];
    assign wd_bits     = bank_bits(write_data, bank);
    assign bank_sel    = bank_bits({DATA_W{1'b1}}, bank);
    assign pudclk_hit  = bank_bits(write_data, pudclk_bank);

    always_comb
    begin
        fsel_next     = fsel_reg;
        latch_next    = latch_reg;
        ren_next      = ren_reg;
        fen_next      = fen_reg;
        event_next    = event_reg;
        sample_next   = sample_reg;
        pu_next       = pu_reg;
        pd_next       = pd_reg;
        pull_ctl_next = pull_ctl_reg;
        rd_comb       = '0;
        status_comb   = STATUS_OK;

        if (command == CMD_SAMPLE)
        begin
            event_next  = event_reg
                        | (pin_levels & ~sample_reg & ren_reg)
                        | (~pin_levels & sample_reg & fen_reg);
            sample_next = pin_levels;
        end
        else if (command == CMD_WRITE || command == CMD_READ)
        begin
            priority if (reg_index > REG_PUDCLK1)
            begin
                status_comb = STATUS_UNMAPPED;
            end
            else if (reg_index <= REG_FSEL_LAST)
            begin
                if (wr)
                begin
                    fsel_next[fsel_idx] = write_data[FSEL_WORD_W-1:0] & fsel_mask[fsel_idx];
                end
                else
                begin
                    rd_comb = DATA_W'(fsel_reg[fsel_idx]);
                end
            end
            else if (reg_index <= REG_SET_LAST)
            begin
                if (wr)
                begin
                    latch_next = latch_reg | wd_bits;
                end
            end
            else if (reg_index <= REG_CLR_LAST)
            begin
                if (wr)
                begin
                    latch_next = latch_reg & ~wd_bits;
                end
            end
            else if (reg_index <= REG_LEV_LAST)
            begin
                if (!wr)
                begin
                    rd_comb = bank_word(sample_reg, bank);
                end
            end
            else if (reg_index <= REG_EDS_LAST)
            begin
                // write one to clear
                if (wr)
                begin
                    event_next = event_reg & ~wd_bits;
                end
                else
                begin
                    rd_comb = bank_word(event_reg, bank);
                end
            end
            else if (reg_index <= REG_REN_LAST)
            begin
                if (wr)
                begin
                    ren_next = (ren_reg & ~bank_sel) | wd_bits;
                end
                else
                begin
                    rd_comb = bank_word(ren_reg, bank);
                end
            end
            else if (reg_index <= REG_FEN_LAST)
            begin
                if (wr)
                begin
                    fen_next = (fen_reg & ~bank_sel) | wd_bits;
                end
                else
                begin
                    rd_comb = bank_word(fen_reg, bank);
                end
            end
            else if (reg_index == REG_PUD)
            begin
                if (wr)
                begin
                    pull_ctl_next = write_data[1:0];
                end
                else
                begin
                    rd_comb = DATA_W'(pull_ctl_reg);
                end
            end
            else
            begin
                // pudclk: latch the pull code into every pin written as 1
                if (wr)
                begin
                    pu_next = (pu_reg & ~pudclk_hit)
                            | (pudclk_hit & {NUM_PINS{pull_ctl_reg == PULL_UP}});
                    pd_next = (pd_reg & ~pudclk_hit)
                            | (pudclk_hit & {NUM_PINS{pull_ctl_reg == PULL_DOWN}});
                end
            end
        end
    end

    for (genvar p = 0; p < NUM_PINS; p++)
    begin : g_oe
        assign oe_comb[p] =
            (fsel_next[p / FSEL_FIELDS][(p % FSEL_FIELDS) * FSEL_W +: FSEL_W] == FSEL_OUTPUT);
    end

    assign event_wide = WIDE_W'(event_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < FSEL_REGS; w++)
            begin
                fsel_reg[w] <= '0;
            end
            latch_reg    <= '0;
            ren_reg      <= '0;
            fen_reg      <= '0;
            event_reg    <= '0;
            sample_reg   <= '0;
            pu_reg       <= '0;
            pd_reg       <= '0;
            pull_ctl_reg <= '0;
        end
        else if (load)
        begin
            fsel_reg     <= fsel_next;
            latch_reg    <= latch_next;
            ren_reg      <= ren_next;
            fen_reg      <= fen_next;
            event_reg    <= event_next;
            sample_reg   <= sample_next;
            pu_reg       <= pu_next;
            pd_reg       <= pd_next;
            pull_ctl_reg <= pull_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_out_reg     <= rd_comb;
            status_out_reg <= status_comb;
            level_out_reg  <= latch_next;
            oe_out_reg     <= oe_comb;
            pu_out_reg     <= pu_next;
            pd_out_reg     <= pd_next;
            irq0_out_reg   <= |event_wide[DATA_W-1:0];
            irq1_out_reg   <= |event_wide[WIDE_W-1:DATA_W];
        end
    end

    assign read_data      = rd_out_reg;
    assign status         = status_out_reg;
    assign out_level      = level_out_reg;
    assign out_enable     = oe_out_reg;
    assign pull_up_mask   = pu_out_reg;
    assign pull_down_mask = pd_out_reg;
    assign irq_bank0      = irq0_out_reg;
    assign irq_bank1      = irq1_out_reg;

endmodule
